// ===== rtl/oebb_pkg.sv =====
// shared types and fixed widths for the ellipsoid bounding box pipeline
package oebb_pkg;

    // fixed field widths
    localparam int RAD_W      = 31;
    localparam int ROT_W      = 16;
    localparam int ROT_FRAC   = 14;
    localparam int ROW_W      = 3 * ROT_W;
    localparam int MAG_W      = 16;
    localparam int PROD_W     = MAG_W + RAD_W;
    localparam int FLR_W      = PROD_W - ROT_FRAC;
    localparam int MARGIN_W   = 16;
    localparam logic [MARGIN_W-1:0] MARGIN_RESET = 16'd7;

    // per-stage load enables handed to each axis lane
    typedef struct packed {
        logic mul;
        logic split;
        logic sum;
    } oebb_adv_t;

endpackage

// ===== rtl/oriented_ellipsoid_bounding_box.sv =====
// Axis-aligned bounding box of a rotated ellipsoid's box, five stages deep.
// One item (centre, three radii, rotation rows) enters per clock and its box
// leaves after the clamp stage; the throughput is one item a cycle, set by the
// fully pipelined multiply, split, sum and clamp stages, and falls only when
// m_tready holds results back. Each stage loads whenever it is empty or the
// stage after it moves, so back-pressure fills empty slots before stalling
// s_tready. Rotation entries are Q1.14; radii and centre are Q15.16, margin is
// Q0.16; bounds saturate to COORD_WIDTH bits. The margin register resets to 7 and
// is written through cfg_valid/cfg_data, always ready.
module oriented_ellipsoid_bounding_box
    import oebb_pkg::*;
#(
    parameter int COORD_WIDTH = 32
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    // margin register write
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [MARGIN_W-1:0]       cfg_data,
    // input items
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // center_x, center_y, center_z, radius_x, radius_y, radius_z,
    // rot_row_a, rot_row_b, rot_row_c, zero fill
    input  logic [((3*COORD_WIDTH+3*RAD_W+3*ROW_W+7)/8)*8-1:0] s_tdata,
    // result items
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // min_x, min_y, min_z, max_x, max_y, max_z, zero fill
    output logic [((6*COORD_WIDTH+7)/8)*8-1:0] m_tdata
);

    localparam int OUT_TDATA_W = ((6*COORD_WIDTH+7)/8)*8;
    localparam int OFF_RAD     = 3 * COORD_WIDTH;
    localparam int OFF_ROT     = OFF_RAD + 3 * RAD_W;
    localparam int SUM_W       = ((COORD_WIDTH > FLR_W + 1) ? COORD_WIDTH : FLR_W + 1) + 3;

    logic [MARGIN_W-1:0]               margin_reg;
    logic                              v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic                              en1, en2, en3, en4, en5;
    oebb_adv_t                         adv;
    logic [2:0][COORD_WIDTH-1:0]       c1_reg, c1_next;
    logic [2:0][RAD_W-1:0]             r1_reg, r1_next;
    logic [2:0][2:0][MAG_W-1:0]        mag1_reg, mag1_next;
    logic [2:0][SUM_W-1:0]             lo, hi;
    logic [5:0][COORD_WIDTH-1:0]       bound;
    logic [ROT_W-1:0]                  entry;

    // margin register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            margin_reg <= MARGIN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            margin_reg <= cfg_data;
        end
    end

    // stage load enables, chained back from the output
    always_comb
    begin
        en5 = !v5_reg || m_tready;
        en4 = !v4_reg || en5;
        en3 = !v3_reg || en4;
        en2 = !v2_reg || en3;
        en1 = !v1_reg || en2;
        adv.mul   = en2;
        adv.split = en3;
        adv.sum   = en4;
    end

    assign s_tready = en1;
    assign m_tvalid = v5_reg;

    // valid bits travel with the items
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= s_tvalid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
        end
    end

    // unpack the item and take magnitudes of the rotation entries
    always_comb
    begin
        entry = '0;
        for (int i = 0; i < 3; i++)
        begin
            c1_next[i] = s_tdata[i*COORD_WIDTH +: COORD_WIDTH];
            r1_next[i] = s_tdata[OFF_RAD + i*RAD_W +: RAD_W];
            for (int j = 0; j < 3; j++)
            begin
                entry = s_tdata[OFF_ROT + i*ROW_W + j*ROT_W +: ROT_W];
                mag1_next[i][j] = entry[ROT_W-1] ? (~entry + 1'b1) : entry;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            c1_reg   <= c1_next;
            r1_reg   <= r1_next;
            mag1_reg <= mag1_next;
        end
    end

    // one lane per output axis
    for (genvar i = 0; i < 3; i++)
    begin : g_axis
        oebb_axis #(
            .COORD_WIDTH (COORD_WIDTH),
            .SUM_W       (SUM_W)
        ) u_axis (
            .clk     (clk),
            .adv     (adv),
            .center  ($signed(c1_reg[i])),
            .radius  (r1_reg),
            .rot_mag (mag1_reg[i]),
            .lo      (lo[i]),
            .hi      (hi[i])
        );
    end

    // margin and saturation
    oebb_clamp #(
        .COORD_WIDTH (COORD_WIDTH),
        .SUM_W       (SUM_W)
    ) u_clamp (
        .clk    (clk),
        .en     (en5),
        .margin (margin_reg),
        .lo     (lo),
        .hi     (hi),
        .bound  (bound)
    );

    assign m_tdata = OUT_TDATA_W'({bound[5], bound[4], bound[3],
                                   bound[2], bound[1], bound[0]});

    // an empty or draining output stage never blocks the input
    a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (!v5_reg || m_tready) |-> s_tready)
        else $error("input stalled while output stage could move");

    // an accepted item lands in the first stage
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> v1_reg)
        else $error("accepted item lost at first stage");

    // an item leaving the sum stage reaches the output
    a_sum_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (v4_reg && en5) |=> m_tvalid)
        else $error("item lost between sum and output stages");

endmodule

// ===== rtl/oebb_axis.sv =====
// one output axis: products, floor and ceiling split, and corner extreme sums
module oebb_axis
    import oebb_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int SUM_W       = 37
)
(
    input  logic                          clk,
    input  oebb_adv_t                     adv,
    input  logic signed [COORD_WIDTH-1:0] center,
    input  logic [2:0][RAD_W-1:0]         radius,
    input  logic [2:0][MAG_W-1:0]         rot_mag,
    output logic signed [SUM_W-1:0]       lo,
    output logic signed [SUM_W-1:0]       hi
);

    logic [2:0][PROD_W-1:0]         prod_reg, prod_next;
    logic signed [COORD_WIDTH-1:0]  c2_reg;
    logic [2:0][FLR_W-1:0]          flr_reg, flr_next;
    logic [2:0][FLR_W-1:0]          ceil_reg, ceil_next;
    logic signed [COORD_WIDTH-1:0]  c3_reg;
    logic signed [SUM_W-1:0]        lo_reg, lo_next;
    logic signed [SUM_W-1:0]        hi_reg, hi_next;
    logic signed [SUM_W-1:0]        c_ext;
    logic signed [SUM_W-1:0]        flr_sum;
    logic signed [SUM_W-1:0]        ceil_sum;

    // magnitude products |R| * r, one per column
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            prod_next[j] = {{(PROD_W-MAG_W){1'b0}}, rot_mag[j]}
                         * {{(PROD_W-RAD_W){1'b0}}, radius[j]};
        end
    end

    // floor and ceiling of each product over 2^14; the larger corner
    // term is the floor, the smaller is minus the ceiling
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            flr_next[j]  = prod_reg[j][PROD_W-1:ROT_FRAC];
            ceil_next[j] = prod_reg[j][PROD_W-1:ROT_FRAC]
                         + {{(FLR_W-1){1'b0}}, |prod_reg[j][ROT_FRAC-1:0]};
        end
    end

    // extreme corner coordinates along this axis
    always_comb
    begin
        c_ext    = {{(SUM_W-COORD_WIDTH){c3_reg[COORD_WIDTH-1]}}, c3_reg};
        flr_sum  = $signed({{(SUM_W-FLR_W){1'b0}}, flr_reg[0]})
                 + $signed({{(SUM_W-FLR_W){1'b0}}, flr_reg[1]})
                 + $signed({{(SUM_W-FLR_W){1'b0}}, flr_reg[2]});
        ceil_sum = $signed({{(SUM_W-FLR_W){1'b0}}, ceil_reg[0]})
                 + $signed({{(SUM_W-FLR_W){1'b0}}, ceil_reg[1]})
                 + $signed({{(SUM_W-FLR_W){1'b0}}, ceil_reg[2]});
        hi_next  = c_ext + flr_sum;
        lo_next  = c_ext - ceil_sum;
    end

    // stage registers
    always_ff @(posedge clk)
    begin
        if (adv.mul)
        begin
            prod_reg <= prod_next;
            c2_reg   <= center;
        end
        if (adv.split)
        begin
            flr_reg  <= flr_next;
            ceil_reg <= ceil_next;
            c3_reg   <= c2_reg;
        end
        if (adv.sum)
        begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
    end

    assign lo = lo_reg;
    assign hi = hi_reg;

endmodule

// ===== rtl/oebb_clamp.sv =====
// margin add and saturation into the output register
module oebb_clamp
    import oebb_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int SUM_W       = 37
)
(
    input  logic                                clk,
    input  logic                                en,
    input  logic [MARGIN_W-1:0]                 margin,
    input  logic [2:0][SUM_W-1:0]               lo,
    input  logic [2:0][SUM_W-1:0]               hi,
    output logic [5:0][COORD_WIDTH-1:0]         bound
);

    logic [5:0][COORD_WIDTH-1:0] bound_reg, bound_next;
    logic [5:0][SUM_W-1:0]       wide;
    logic [SUM_W-1:0]            margin_ext;

    // widen margin, apply it and clamp each bound to the coordinate range
    always_comb
    begin
        margin_ext = {{(SUM_W-MARGIN_W){1'b0}}, margin};
        for (int i = 0; i < 3; i++)
        begin
            wide[i]     = lo[i] - margin_ext;
            wide[3 + i] = hi[i] + margin_ext;
        end
        for (int k = 0; k < 6; k++)
        begin
            if ((&wide[k][SUM_W-1:COORD_WIDTH-1]) || !(|wide[k][SUM_W-1:COORD_WIDTH-1]))
            begin
                bound_next[k] = wide[k][COORD_WIDTH-1:0];
            end
            else if (wide[k][SUM_W-1])
            begin
                bound_next[k] = {1'b1, {(COORD_WIDTH-1){1'b0}}};
            end
            else
            begin
                bound_next[k] = {1'b0, {(COORD_WIDTH-1){1'b1}}};
            end
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bound_reg <= bound_next;
        end
    end

    assign bound = bound_reg;

endmodule

// ===== bench/oriented_ellipsoid_bounding_box_test.sv =====
// self-checking bench for the ellipsoid bounding box pipeline: directed and random items
module oriented_ellipsoid_bounding_box_test;
    import oebb_pkg::*;

    localparam int CW            = 32;
    localparam int IN_W          = ((3*CW + 3*RAD_W + 3*ROW_W + 7) / 8) * 8;
    localparam int OUT_W         = ((6*CW + 7) / 8) * 8;
    localparam int PHASES        = 6;
    localparam int ITEMS_PER_SET = 275;
    localparam int SETTLE_CYCLES = 12;
    localparam int QUIET_LIMIT   = 2000;

    localparam logic [15:0]      ONE_Q14     = 16'h4000;
    localparam logic [15:0]      NEG_ONE_Q14 = 16'hC000;
    localparam logic [15:0]      ROT_MAX     = 16'h7FFF;
    localparam logic [15:0]      ROT_MIN     = 16'h8000;
    localparam logic [CW-1:0]    COORD_MAX   = 32'h7FFF_FFFF;
    localparam logic [CW-1:0]    COORD_MIN   = 32'h8000_0000;
    localparam logic [RAD_W-1:0] RAD_MAX     = 31'h7FFF_FFFF;
    localparam logic [RAD_W-1:0] UNIT        = 31'd65536;

    // one ellipsoid, centre_x in the lowest bits
    typedef struct packed {
        logic [ROW_W-1:0]    rot_row_c;
        logic [ROW_W-1:0]    rot_row_b;
        logic [ROW_W-1:0]    rot_row_a;
        logic [RAD_W-1:0]    radius_z;
        logic [RAD_W-1:0]    radius_y;
        logic [RAD_W-1:0]    radius_x;
        logic signed [CW-1:0] center_z;
        logic signed [CW-1:0] center_y;
        logic signed [CW-1:0] center_x;
    } ellipsoid_t;

    // one bounding box, min_x in the lowest bits
    typedef struct packed {
        logic signed [CW-1:0] max_z;
        logic signed [CW-1:0] max_y;
        logic signed [CW-1:0] max_x;
        logic signed [CW-1:0] min_z;
        logic signed [CW-1:0] min_y;
        logic signed [CW-1:0] min_x;
    } box_t;

    // predicts each box and compares the block's boxes in order
    class box_scoreboard;
        box_t                predicted_boxes[$];
        logic [MARGIN_W-1:0] margin;
        int unsigned         errors;
        int unsigned         checked;
        string               field_names[6] = '{"min_x", "min_y", "min_z",
                                                "max_x", "max_y", "max_z"};

        function new();
            margin  = MARGIN_RESET;
            errors  = 0;
            checked = 0;
        endfunction

        function int pending();
            return predicted_boxes.size();
        endfunction

        // clamp to the signed coordinate range
        function logic [CW-1:0] clamp_coord(longint v);
            if (v > 64'sd2147483647)
                return COORD_MAX;
            if (v < -64'sd2147483648)
                return COORD_MIN;
            return v[CW-1:0];
        endfunction

        // sweep the eight box corners through the rotation
        function void note_ellipsoid(ellipsoid_t e);
            longint           centre[3];
            longint           rad[3];
            longint           lo[3];
            longint           hi[3];
            longint           corner[3];
            longint           q;
            logic [ROW_W-1:0] rows[3];
            logic signed [ROT_W-1:0] rot[3][3];
            box_t             b;
            centre[0] = longint'(e.center_x);
            centre[1] = longint'(e.center_y);
            centre[2] = longint'(e.center_z);
            rad[0]    = longint'(e.radius_x);
            rad[1]    = longint'(e.radius_y);
            rad[2]    = longint'(e.radius_z);
            rows[0]   = e.rot_row_a;
            rows[1]   = e.rot_row_b;
            rows[2]   = e.rot_row_c;
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    rot[i][j] = rows[i][ROT_W*j +: ROT_W];
            for (int k = 0; k < 8; k++)
            begin
                for (int j = 0; j < 3; j++)
                    corner[j] = ((k >> j) & 1) ? rad[j] : -rad[j];
                for (int i = 0; i < 3; i++)
                begin
                    q = centre[i];
                    // arithmetic shift of a signed product floors it
                    for (int j = 0; j < 3; j++)
                        q += (longint'(rot[i][j]) * corner[j]) >>> ROT_FRAC;
                    if (k == 0 || q < lo[i])
                        lo[i] = q;
                    if (k == 0 || q > hi[i])
                        hi[i] = q;
                end
            end
            b.min_x = clamp_coord(lo[0] - longint'(margin));
            b.min_y = clamp_coord(lo[1] - longint'(margin));
            b.min_z = clamp_coord(lo[2] - longint'(margin));
            b.max_x = clamp_coord(hi[0] + longint'(margin));
            b.max_y = clamp_coord(hi[1] + longint'(margin));
            b.max_z = clamp_coord(hi[2] + longint'(margin));
            predicted_boxes.push_back(b);
        endfunction

        // compare against the oldest prediction, field by field
        function void check_box(box_t got);
            box_t want;
            if (predicted_boxes.size() == 0)
            begin
                $display("%0t unexpected box %h", $time, got);
                errors++;
                return;
            end
            want = predicted_boxes.pop_front();
            checked++;
            for (int i = 0; i < 6; i++)
                if (got[CW*i +: CW] !== want[CW*i +: CW])
                begin
                    $display("%0t mismatch %s: expected %h, got %h", $time,
                             field_names[i], want[CW*i +: CW], got[CW*i +: CW]);
                    errors++;
                end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [MARGIN_W-1:0] cfg_data;
    logic               s_tvalid;
    logic               s_tready;
    logic [IN_W-1:0]    s_tdata;
    logic               m_tvalid;
    logic               m_tready;
    logic [OUT_W-1:0]   m_tdata;

    box_scoreboard sb;
    int unsigned   gap_percent   = 0;
    int unsigned   stall_percent = 0;
    int unsigned   items_sent    = 0;
    int unsigned   settings_used = 1;
    int unsigned   quiet_cycles  = 0;

    oriented_ellipsoid_bounding_box #(
        .COORD_WIDTH (CW)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // watch both streams and the register port
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_ellipsoid(ellipsoid_t'(s_tdata[$bits(ellipsoid_t)-1:0]));
            if (m_tvalid && m_tready)
                sb.check_box(box_t'(m_tdata));
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t no item moved for %0d cycles", $time, quiet_cycles);
                $display("FAIL oriented_ellipsoid_bounding_box");
                $finish;
            end
        end
    end

    // result side back-pressure in bursts
    initial
    begin
        forever
        begin
            if (stall_percent != 0 && $urandom_range(0, 99) < stall_percent)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    function automatic logic [ROW_W-1:0] make_row(logic [15:0] c0, logic [15:0] c1,
                                                  logic [15:0] c2);
        return {c2, c1, c0};
    endfunction

    function automatic ellipsoid_t make_ellipsoid(
        logic [CW-1:0] cx, logic [CW-1:0] cy, logic [CW-1:0] cz,
        logic [RAD_W-1:0] rx, logic [RAD_W-1:0] ry, logic [RAD_W-1:0] rz,
        logic [ROW_W-1:0] ra, logic [ROW_W-1:0] rb, logic [ROW_W-1:0] rc);
        ellipsoid_t e;
        e.center_x = cx;
        e.center_y = cy;
        e.center_z = cz;
        e.radius_x = rx;
        e.radius_y = ry;
        e.radius_z = rz;
        e.rot_row_a = ra;
        e.rot_row_b = rb;
        e.rot_row_c = rc;
        return e;
    endfunction

    // style 0 raw bits, 1 plausible scene values, otherwise corner values
    function automatic logic [15:0] rot_entry(int unsigned style);
        if (style == 0)
            return 16'($urandom);
        if (style == 1)
            return 16'($urandom_range(0, 32768) - 16384);
        case ($urandom_range(0, 5))
            0:       return ROT_MIN;
            1:       return ROT_MAX;
            2:       return ONE_Q14;
            3:       return NEG_ONE_Q14;
            4:       return 16'hFFFF;
            default: return 16'h0000;
        endcase
    endfunction

    function automatic logic [CW-1:0] coord_value(int unsigned style);
        if (style == 0)
            return $urandom;
        if (style == 1)
            return $urandom_range(0, 32'h3FFF_FFFF) - 32'h2000_0000;
        case ($urandom_range(0, 5))
            0:       return COORD_MIN;
            1:       return COORD_MAX;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'd1;
            4:       return 32'd65536;
            default: return 32'd0;
        endcase
    endfunction

    function automatic logic [RAD_W-1:0] radius_value(int unsigned style);
        if (style == 0)
            return 31'($urandom);
        if (style == 1)
            return 31'($urandom_range(0, 32'h00FF_FFFF));
        case ($urandom_range(0, 3))
            0:       return RAD_MAX;
            1:       return 31'd1;
            2:       return UNIT;
            default: return 31'd0;
        endcase
    endfunction

    // mix of raw, plausible, corner-value and signed permutation items
    function automatic ellipsoid_t random_ellipsoid();
        ellipsoid_t       e;
        int unsigned      pick;
        int unsigned      style;
        int               col[3];
        int               s;
        int               t;
        logic [ROW_W-1:0] rows[3];
        pick  = $urandom_range(0, 99);
        style = (pick < 30) ? 0 : (pick < 65) ? 1 : 2;
        e.center_x = coord_value(style);
        e.center_y = coord_value(style);
        e.center_z = coord_value(style);
        e.radius_x = radius_value(style);
        e.radius_y = radius_value(style);
        e.radius_z = radius_value(style);
        for (int i = 0; i < 3; i++)
            rows[i] = make_row(rot_entry(style), rot_entry(style), rot_entry(style));
        // signed permutation: each row picks one column
        if (pick >= 85)
        begin
            col = '{0, 1, 2};
            for (int i = 2; i > 0; i--)
            begin
                s      = $urandom_range(0, i);
                t      = col[i];
                col[i] = col[s];
                col[s] = t;
            end
            for (int i = 0; i < 3; i++)
            begin
                rows[i] = '0;
                rows[i][ROT_W*col[i] +: ROT_W] = $urandom_range(0, 1) ? ONE_Q14 : NEG_ONE_Q14;
            end
        end
        e.rot_row_a = rows[0];
        e.rot_row_b = rows[1];
        e.rot_row_c = rows[2];
        return e;
    endfunction

    // offer one item, possibly after a gap, and hold it until taken
    task automatic send_ellipsoid(input ellipsoid_t e);
        if (gap_percent != 0 && $urandom_range(0, 99) < gap_percent)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_W'(e);
        do @(posedge clk); while (!s_tready);
        items_sent++;
    endtask

    // stop sending and let every box come out
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_margin(input logic [MARGIN_W-1:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.margin = value;
        settings_used++;
    endtask

    // main sequence
    initial
    begin
        logic [MARGIN_W-1:0] next_margin;
        sb        = new();
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed items under the reset margin
        gap_percent   = 30;
        stall_percent = 30;
        // all zero
        send_ellipsoid(make_ellipsoid(0, 0, 0, 0, 0, 0, 0, 0, 0));
        // zero radii: box is the centre widened by the margin
        send_ellipsoid(make_ellipsoid(32'd123456, -32'sd98765, 32'd7, 0, 0, 0,
            make_row(ONE_Q14, 0, 0), make_row(0, ONE_Q14, 0), make_row(0, 0, ONE_Q14)));
        // identity with unit-sized radii
        send_ellipsoid(make_ellipsoid(0, 0, 0, UNIT, 2*UNIT, 3*UNIT,
            make_row(ONE_Q14, 0, 0), make_row(0, ONE_Q14, 0), make_row(0, 0, ONE_Q14)));
        // overflow past the top and the bottom of the range
        send_ellipsoid(make_ellipsoid(COORD_MAX, COORD_MAX, COORD_MAX, RAD_MAX, RAD_MAX,
            RAD_MAX, make_row(ONE_Q14, 0, 0), make_row(0, ONE_Q14, 0), make_row(0, 0, ONE_Q14)));
        send_ellipsoid(make_ellipsoid(COORD_MIN, COORD_MIN, COORD_MIN, RAD_MAX, RAD_MAX,
            RAD_MAX, make_row(ONE_Q14, 0, 0), make_row(0, ONE_Q14, 0), make_row(0, 0, ONE_Q14)));
        // most negative and most positive entries everywhere
        send_ellipsoid(make_ellipsoid(0, 0, 0, RAD_MAX, RAD_MAX, RAD_MAX,
            make_row(ROT_MIN, ROT_MIN, ROT_MIN), make_row(ROT_MIN, ROT_MIN, ROT_MIN),
            make_row(ROT_MIN, ROT_MIN, ROT_MIN)));
        send_ellipsoid(make_ellipsoid(COORD_MIN, COORD_MIN, COORD_MIN, RAD_MAX, RAD_MAX,
            RAD_MAX, make_row(ROT_MAX, ROT_MAX, ROT_MAX), make_row(ROT_MAX, ROT_MAX, ROT_MAX),
            make_row(ROT_MAX, ROT_MAX, ROT_MAX)));
        send_ellipsoid(make_ellipsoid(COORD_MAX, COORD_MAX, COORD_MAX, RAD_MAX, RAD_MAX,
            RAD_MAX, make_row(ROT_MAX, ROT_MAX, ROT_MAX), make_row(ROT_MIN, ROT_MIN, ROT_MIN),
            make_row(ROT_MAX, ROT_MIN, ROT_MAX)));
        // tiny products: floor pulls negative ones down, positive ones to zero
        send_ellipsoid(make_ellipsoid(0, 0, 0, 1, 1, 1,
            make_row(16'hFFFF, 16'hFFFF, 16'hFFFF), make_row(16'hFFFF, 1, 16'hFFFF),
            make_row(1, 1, 1)));
        send_ellipsoid(make_ellipsoid(32'hFFFF_FFFF, 1, 0, 3, 16383, 16385,
            make_row(1, 16'hFFFF, 1), make_row(16'h3FFF, 16'hC001, 0), make_row(0, 1, 2)));
        // centre at both ends, zero radii: box is the centre widened by the margin
        send_ellipsoid(make_ellipsoid(COORD_MIN, COORD_MAX, 0, 0, 0, 0, 0, 0, 0));
        // negated permutation
        send_ellipsoid(make_ellipsoid(32'd5000000, -32'sd7000000, 32'd65536, 10*UNIT,
            UNIT, 31'd3000, make_row(0, NEG_ONE_Q14, 0), make_row(0, 0, NEG_ONE_Q14),
            make_row(NEG_ONE_Q14, 0, 0)));
        // non-orthonormal matrix used as given
        send_ellipsoid(make_ellipsoid(32'd1000, 32'd2000, -32'sd3000, 31'd777777, 31'd123,
            31'd99999999, make_row(16'd12345, 16'hA460, 16'd30000),
            make_row(16'h8001, 16'd1, 16'h7FFE), make_row(16'd5, 16'hFFFB, 16'd20000)));
        // one long axis with mixed extreme entries
        send_ellipsoid(make_ellipsoid(0, COORD_MAX, COORD_MIN, RAD_MAX, 0, 0,
            make_row(ROT_MAX, ROT_MIN, 0), make_row(ROT_MIN, ROT_MAX, 0),
            make_row(ROT_MAX, 0, ROT_MIN)));
        // forty-five degree turn about z
        send_ellipsoid(make_ellipsoid(32'd65536, 32'd65536, 0, 4*UNIT, UNIT, 2*UNIT,
            make_row(16'd11585, 16'hD2BF, 0), make_row(16'd11585, 16'd11585, 0),
            make_row(0, 0, ONE_Q14)));
        send_ellipsoid(make_ellipsoid(COORD_MAX, COORD_MIN, COORD_MAX, RAD_MAX, RAD_MAX,
            RAD_MAX, make_row(ROT_MIN, ROT_MIN, ROT_MIN), make_row(ROT_MAX, ROT_MAX, ROT_MAX),
            make_row(ROT_MIN, ROT_MAX, ROT_MIN)));

        // random sets, each under its own margin; the last without idling
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:       next_margin = '0;
                1:       next_margin = '1;
                3:       next_margin = 16'd1;
                default: next_margin = 16'($urandom);
            endcase
            write_margin(next_margin);
            case (ph)
                0:       begin gap_percent = 20; stall_percent = 20; end
                1:       begin gap_percent = 40; stall_percent = 10; end
                2:       begin gap_percent = 10; stall_percent = 45; end
                3:       begin gap_percent = 0;  stall_percent = 0;  end
                4:       begin gap_percent = 30; stall_percent = 30; end
                default: begin gap_percent = 0;  stall_percent = 0;  end
            endcase
            repeat (ITEMS_PER_SET) send_ellipsoid(random_ellipsoid());
        end

        wait_idle();
        $display("%0d ellipsoids sent, %0d boxes checked under %0d margin values",
                 items_sent, sb.checked, settings_used);
        $display("random gaps and back-pressure in bursts, last set streamed back to back");
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS oriented_ellipsoid_bounding_box");
        else
            $display("FAIL oriented_ellipsoid_bounding_box");
        $finish;
    end

endmodule
